// ===== rtl/core/htxt_pkg.sv =====
// shared types, character codes and output slot codes for the hex text emitter
// no dependencies
`timescale 1ns / 1ps

package htxt_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BYTES_PER_LINE    = 2'd0;
    localparam logic [1:0] REG_MIN_ADDRESS_BYTES = 2'd1;

    // ascii codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // address thresholds for 3 and 4 byte address lines
    localparam logic [31:0] ADDR_3BYTE = 32'h0001_0000;
    localparam logic [31:0] ADDR_4BYTE = 32'h0100_0000;

    // output slots, emitted in this order when enabled
    localparam int NSLOTS = 17;
    localparam logic [4:0] SLOT_NL_PRE   = 5'd0;
    localparam logic [4:0] SLOT_AT       = 5'd1;
    localparam logic [4:0] SLOT_DIG_FIRST = 5'd2;   // most significant address nibble
    localparam logic [4:0] SLOT_DIG_LAST  = 5'd9;   // least significant address nibble
    localparam logic [4:0] SLOT_NL_ADDR  = 5'd10;
    localparam logic [4:0] SLOT_NL_WRAP  = 5'd11;
    localparam logic [4:0] SLOT_SPACE    = 5'd12;
    localparam logic [4:0] SLOT_HI       = 5'd13;
    localparam logic [4:0] SLOT_LO       = 5'd14;
    localparam logic [4:0] SLOT_Q        = 5'd15;
    localparam logic [4:0] SLOT_NL_END   = 5'd16;

    typedef logic [NSLOTS-1:0] t_mask;

    typedef struct packed {
        logic [7:0] bytes_per_line;
        logic [2:0] min_address_bytes;
    } t_cfg;

    typedef struct packed {
        t_mask       mask;
        logic [31:0] addr;
        logic [7:0]  data;
    } t_plan;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + {4'd0, v};
        end
        return CH_UPPER_A + {4'd0, v - 4'd10};
    endfunction

    function automatic logic [7:0] slot_char(input logic [4:0] slot,
                                             input logic [31:0] addr,
                                             input logic [7:0] data);
        logic [4:0] nib_pos;
        logic [7:0] ch;
        nib_pos = SLOT_DIG_LAST - slot;
        if (slot >= SLOT_DIG_FIRST && slot <= SLOT_DIG_LAST) begin
            ch = hex_digit(addr[{nib_pos[2:0], 2'b00} +: 4]);
        end else begin
            case (slot)
                SLOT_NL_PRE, SLOT_NL_ADDR, SLOT_NL_WRAP, SLOT_NL_END: ch = CH_NL;
                SLOT_AT:    ch = CH_AT;
                SLOT_SPACE: ch = CH_SPACE;
                SLOT_HI:    ch = hex_digit(data[7:4]);
                SLOT_LO:    ch = hex_digit(data[3:0]);
                SLOT_Q:     ch = CH_Q;
                default:    ch = CH_NL;
            endcase
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/hex_text_load_file_emitter.sv =====
// Hex load-file text emitter: each request (a data byte at an address, or an end-of-file
// command) becomes a run of ASCII characters on the output channel, one character per
// cycle unless the output stalls, with o_last_char marking the final character of the
// request. A data byte that continues the current address costs three characters (two hex
// digits, after a space or after a newline on wrap); a byte that starts a new address line
// costs up to thirteen; end of file costs two or three. Throughput is one character per
// cycle while the receiver does not stall, set by the single output register. A request is
// held in the input register until its character plan is loaded, once the serializer is empty
// or the previous plan's last character goes out; the input stalls only while one is held.
// Configuration writes (index 0 bytes per line, index 1 minimum address bytes) are always
// ready and must only be issued while the block is idle.
`timescale 1ns / 1ps

module hex_text_load_file_emitter #(
    parameter int ADDRESS_BITS   = 32,
    parameter int MAX_LINE_BYTES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [31:0] i_byte_address,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);
    import htxt_pkg::*;

    t_cfg  r_cfg;
    t_plan plan;
    logic  plan_valid;
    logic  plan_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_line    <= 8'd16;
            r_cfg.min_address_bytes <= 3'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BYTES_PER_LINE:    r_cfg.bytes_per_line    <= i_cfg_data;
                REG_MIN_ADDRESS_BYTES: r_cfg.min_address_bytes <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    htxt_plan #(
        .ADDRESS_BITS   (ADDRESS_BITS),
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_plan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_byte_address (i_byte_address),
        .i_data_byte    (i_data_byte),
        .o_plan         (plan),
        .o_plan_valid   (plan_valid),
        .i_plan_ready   (plan_ready)
    );

    htxt_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan       (plan),
        .i_plan_valid (plan_valid),
        .o_plan_ready (plan_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

`ifndef SYNTHESIS
    // the input only stalls behind a request already held
    a_stall_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> plan_valid)
        else $error("input stalled with no request held");

    // a request always ends on a newline or a data digit
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_char) |->
            (o_out_char == CH_NL ||
             (o_out_char >= CH_ZERO && o_out_char <= 8'h39) ||
             (o_out_char >= CH_UPPER_A && o_out_char <= 8'h46)))
        else $error("request ended on an unexpected character");

    // an address marker is always followed by more text
    a_at_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_char == CH_AT) |-> !o_last_char)
        else $error("address marker flagged as last character");
`endif

endmodule

// ===== rtl/core/htxt_plan.sv =====
// input register, line/address state and per-request character plan
// depends on htxt_pkg
`timescale 1ns / 1ps

module htxt_plan #(
    parameter int ADDRESS_BITS   = 32,
    parameter int MAX_LINE_BYTES = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  htxt_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_command,
    input  logic [31:0]     i_byte_address,
    input  logic [7:0]      i_data_byte,
    output htxt_pkg::t_plan o_plan,
    output logic            o_plan_valid,
    input  logic            i_plan_ready
);
    import htxt_pkg::*;

    localparam int ColW = $clog2(MAX_LINE_BYTES + 1);

    logic                    r_in_valid;
    logic                    r_in_command;
    logic [31:0]             r_in_addr;
    logic [7:0]              r_in_data;

    logic [ADDRESS_BITS-1:0] r_next_addr;
    logic                    r_known;
    logic [ColW-1:0]         r_col;

    logic                    in_take;
    logic                    fire;
    logic [ADDRESS_BITS-1:0] addr_n;
    logic [31:0]             addr32;
    logic                    new_addr;
    logic [ColW-1:0]         per_line;
    logic [2:0]              min_bytes;
    logic [2:0]              width;
    logic [3:0]              first_dig;
    logic [ColW-1:0]         col_a;
    logic [ColW-1:0]         col_b;
    logic                    wrap;
    t_mask                   mask;
    logic [ADDRESS_BITS-1:0] n_next_addr;
    logic                    n_known;
    logic [ColW-1:0]         n_col;

    assign o_in_stall   = r_in_valid && !i_plan_ready;
    assign in_take      = i_in_valid && !o_in_stall;
    assign fire         = r_in_valid && i_plan_ready;
    assign o_plan_valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !i_plan_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_command <= i_command;
            r_in_addr    <= i_byte_address;
            r_in_data    <= i_data_byte;
        end
    end

    always_comb begin
        addr_n   = r_in_addr[ADDRESS_BITS-1:0];
        addr32   = 32'(addr_n);
        new_addr = !r_known || (r_next_addr != addr_n);

        if (i_cfg.bytes_per_line == 8'd0) begin
            per_line = ColW'(1);
        end else if (32'(i_cfg.bytes_per_line) > MAX_LINE_BYTES) begin
            per_line = ColW'(MAX_LINE_BYTES);
        end else begin
            per_line = ColW'(i_cfg.bytes_per_line);
        end

        if (i_cfg.min_address_bytes < 3'd2) begin
            min_bytes = 3'd2;
        end else if (i_cfg.min_address_bytes > 3'd4) begin
            min_bytes = 3'd4;
        end else begin
            min_bytes = i_cfg.min_address_bytes;
        end

        if (addr32 >= ADDR_4BYTE) begin
            width = 3'd4;
        end else if (addr32 >= ADDR_3BYTE) begin
            width = 3'd3;
        end else begin
            width = 3'd2;
        end
        if (width < min_bytes) begin
            width = min_bytes;
        end
        // index of the first printed digit among the eight digit slots
        first_dig = 4'd8 - {width, 1'b0};

        col_a = new_addr ? '0 : r_col;
        wrap  = col_a >= per_line;
        col_b = wrap ? '0 : col_a;

        mask = '0;
        if (r_in_command) begin
            mask[SLOT_NL_PRE] = (r_col != '0);
            mask[SLOT_Q]      = 1'b1;
            mask[SLOT_NL_END] = 1'b1;
        end else begin
            mask[SLOT_NL_PRE]  = new_addr && (r_col != '0);
            mask[SLOT_AT]      = new_addr;
            for (int k = 0; k < 8; k++) begin
                mask[SLOT_DIG_FIRST + 5'(k)] = new_addr && (4'(k) >= first_dig);
            end
            mask[SLOT_NL_ADDR] = new_addr;
            mask[SLOT_NL_WRAP] = wrap;
            mask[SLOT_SPACE]   = (col_b != '0);
            mask[SLOT_HI]      = 1'b1;
            mask[SLOT_LO]      = 1'b1;
        end

        if (r_in_command) begin
            n_next_addr = r_next_addr;
            n_known     = 1'b0;
            n_col       = '0;
        end else begin
            // a matching address equals the expected one, so both paths step from addr_n
            n_next_addr = addr_n + 1'b1;
            n_known     = 1'b1;
            n_col       = col_b + 1'b1;
        end
    end

    assign o_plan.mask = mask;
    assign o_plan.addr = addr32;
    assign o_plan.data = r_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_addr <= '0;
            r_known     <= 1'b0;
            r_col       <= '0;
        end else if (fire) begin
            r_next_addr <= n_next_addr;
            r_known     <= n_known;
            r_col       <= n_col;
        end
    end

endmodule

// ===== rtl/core/htxt_serial.sv =====
// plan register and character serializer feeding the output register
// depends on htxt_pkg
`timescale 1ns / 1ps

module htxt_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  htxt_pkg::t_plan i_plan,
    input  logic            i_plan_valid,
    output logic            o_plan_ready,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_last_char
);
    import htxt_pkg::*;

    t_mask       r_mask;
    logic [31:0] r_addr;
    logic [7:0]  r_data;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_last_char;

    t_mask       sel;
    logic [4:0]  slot;
    logic        out_free;
    logic        load_out;
    logic        last;
    t_mask       n_mask;

    always_comb begin
        // lowest enabled slot goes out next
        sel  = r_mask & (~r_mask + 1'b1);
        slot = '0;
        for (int i = 0; i < NSLOTS; i++) begin
            if (sel[i]) begin
                slot = slot | 5'(i);
            end
        end
        out_free     = !r_out_valid || !i_out_stall;
        load_out     = out_free && (r_mask != '0);
        last         = (r_mask == sel);
        o_plan_ready = (r_mask == '0) || (load_out && last);
        n_mask       = load_out ? (r_mask & ~sel) : r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= (i_plan_valid && o_plan_ready) ? i_plan.mask : n_mask;
            r_out_valid <= load_out || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_plan_valid && o_plan_ready) begin
            r_addr <= i_plan.addr;
            r_data <= i_plan.data;
        end
        if (load_out) begin
            r_out_char  <= slot_char(slot, r_addr, r_data);
            r_last_char <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last_char;

endmodule

// ===== dv/htxt_text_checker.sv =====
// scoreboard for the hex text emitter: tracks register writes, predicts the text for each
// accepted request and compares every accepted output character in order
// depends on htxt_pkg for register indexes, character codes and address thresholds
`timescale 1ns / 1ps

module htxt_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_command,
    input  logic [31:0] i_byte_address,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_char,
    input  logic        i_last_char,
    output int          o_fail_count,
    output int          o_pending
);

    import htxt_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } t_text_char;

    t_text_char  expected_text[$];

    logic [7:0]  bytes_per_line;
    logic [2:0]  min_address_bytes;
    logic [31:0] next_address;
    logic        address_known;
    logic [7:0]  line_column;
    int          fails = 0;

    function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + {4'd0, v};
        end
        return CH_UPPER_A + {4'd0, v} - 8'd10;
    endfunction

    // appends the characters one request produces, last flag on the final one
    task automatic format_request(input logic cmd, input logic [31:0] addr,
                                  input logic [7:0] data);
        logic [7:0] text[$];
        t_text_char entry;
        int per_line;
        int min_bytes;
        int width;
        int i;
        per_line  = int'(bytes_per_line);
        min_bytes = int'(min_address_bytes);
        if (per_line < 1) per_line = 1;
        if (min_bytes < 2) min_bytes = 2;
        if (min_bytes > 4) min_bytes = 4;
        if (cmd) begin
            if (line_column > 0) text.push_back(CH_NL);
            text.push_back(CH_Q);
            text.push_back(CH_NL);
            line_column   = 0;
            address_known = 1'b0;
        end else begin
            if (!address_known || next_address != addr) begin
                if (line_column > 0) text.push_back(CH_NL);
                line_column   = 0;
                next_address  = addr;
                address_known = 1'b1;
                if (addr >= ADDR_4BYTE) width = 4;
                else if (addr >= ADDR_3BYTE) width = 3;
                else width = 2;
                if (width < min_bytes) width = min_bytes;
                text.push_back(CH_AT);
                for (i = width * 2; i > 0; i--) begin
                    text.push_back(nibble_ascii(addr[(i - 1) * 4 +: 4]));
                end
                text.push_back(CH_NL);
            end
            // also covers a line left longer than a newly lowered limit
            if (line_column >= per_line) begin
                text.push_back(CH_NL);
                line_column = 0;
            end
            if (line_column > 0) text.push_back(CH_SPACE);
            text.push_back(nibble_ascii(data[7:4]));
            text.push_back(nibble_ascii(data[3:0]));
            line_column  = line_column + 8'd1;
            next_address = next_address + 32'd1;
        end
        for (i = 0; i < text.size(); i++) begin
            entry.ch      = text[i];
            entry.is_last = (i == text.size() - 1);
            expected_text.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_text_char want;
        if (!i_rst_n) begin
            bytes_per_line    = 8'd16;
            min_address_bytes = 3'd2;
            next_address      = 32'd0;
            address_known     = 1'b0;
            line_column       = 8'd0;
            expected_text.delete();
        end else begin
            // outputs first: a request taken at this edge cannot have produced them
            if (i_out_valid && !i_out_stall) begin
                if (expected_text.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected char %h last %b with nothing pending",
                                 i_out_char, i_last_char);
                    end
                end else begin
                    want = expected_text.pop_front();
                    if (want.ch !== i_out_char || want.is_last !== i_last_char) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected char %h last %b, got char %h last %b",
                                     want.ch, want.is_last, i_out_char, i_last_char);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BYTES_PER_LINE) begin
                    bytes_per_line = i_cfg_data;
                end else if (i_cfg_index == REG_MIN_ADDRESS_BYTES) begin
                    min_address_bytes = i_cfg_data[2:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                format_request(i_command, i_byte_address, i_data_byte);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_text.size();
    end

endmodule

// ===== dv/tb_hex_text_load_file_emitter.sv =====
// top of the hex text emitter bench: clock, reset, request and register stimulus,
// output backpressure, watchdog and verdict
// depends on htxt_pkg, hex_text_load_file_emitter and htxt_text_checker
`timescale 1ns / 1ps

module tb_hex_text_load_file_emitter;

    import htxt_pkg::*;

    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AFTER     = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 24;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = REG_BYTES_PER_LINE;
    logic [7:0]  cfg_data     = 8'd0;
    logic        in_valid     = 1'b0;
    logic        command      = 1'b0;
    logic [31:0] byte_address = 32'd0;
    logic [7:0]  data_byte    = 8'd0;
    logic        out_stall    = 1'b0;
    logic        cfg_ready;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_char;
    logic        last_char;

    int          fail_count;
    int          pending;
    logic        calm      = 1'b0;
    int          items_sent = 0;
    logic [31:0] run_addr  = 32'd0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          quiet     = 0;

    always #5 clk = ~clk;

    hex_text_load_file_emitter uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_byte_address (byte_address),
        .i_data_byte    (data_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_char     (out_char),
        .o_last_char    (last_char)
    );

    htxt_text_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (command),
        .i_byte_address (byte_address),
        .i_data_byte    (data_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_char     (out_char),
        .i_last_char    (last_char),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    task automatic send_req(input logic cmd, input logic [31:0] addr, input logic [7:0] data);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 37) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        byte_address <= addr;
        data_byte    <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (!cmd) run_addr = addr + 32'd1;
    endtask

    task automatic send_run(input logic [31:0] start, input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_req(1'b0, start + i, 8'($urandom_range(255)));
        end
    endtask

    // drop the request line and let every pending character drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int quota);
        int n;
        int r;
        int len;
        logic [31:0] start;
        n = 0;
        while (n < quota) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_req(1'b1, $urandom, 8'($urandom_range(255)));
                n++;
            end else if (r < 12) begin
                send_req(1'b0, $urandom, 8'($urandom_range(255)));
                n++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(24, 1);
                case ($urandom_range(4))
                    0: start = run_addr;
                    1: start = $urandom_range(32'h0000_FFFF);
                    2: start = $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
                    3: start = $urandom;
                    default: start = 32'hFFFF_FFFF - $urandom_range(20);
                endcase
                send_run(start, len);
                n += len;
            end
        end
    endtask

    // receiver: random stalls, one long hold-off to back the block up into its input
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 37);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        int p;
        logic [7:0] bpl;
        logic [7:0] min_bytes;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: address widths by magnitude, wrap, end handling
        send_req(1'b0, 32'h0000_0000, 8'h00);
        send_req(1'b0, 32'h0000_0001, 8'hFF);
        send_req(1'b0, 32'h0000_FFFF, 8'hA5);
        send_req(1'b0, 32'h0001_0000, 8'h5A);
        send_req(1'b0, 32'h00FF_FFFF, 8'h3C);
        send_req(1'b0, 32'h0123_4567, 8'h96);
        send_req(1'b0, 32'hFFFF_FFFF, 8'h0F);
        send_req(1'b0, 32'h0000_0000, 8'hF0);
        send_req(1'b1, 32'hFFFF_FFFF, 8'hFF);
        send_req(1'b1, 32'h0000_0000, 8'h00);
        // contiguous address after end still needs a fresh address line
        send_run(run_addr, 13);
        // shrink the line below its current length
        wait_idle();
        write_reg(REG_BYTES_PER_LINE, 8'd4);
        send_run(run_addr, 2);
        wait_idle();
        write_reg(REG_MIN_ADDRESS_BYTES, 8'd4);
        send_req(1'b0, 32'h0000_0012, 8'hC3);

        for (p = 0; p < 7; p++) begin
            case (p)
                0: begin bpl = 8'd1;   min_bytes = 8'h04; end
                1: begin bpl = 8'd255; min_bytes = 8'h03; end
                2: begin bpl = 8'd0;   min_bytes = 8'h00; end
                3: begin bpl = 8'd7;   min_bytes = 8'h07; end
                4: begin bpl = 8'd3;   min_bytes = 8'hFD; end
                5: begin bpl = 8'd16;  min_bytes = 8'h02; end
                default: begin
                    bpl       = 8'($urandom_range(255));
                    min_bytes = 8'($urandom_range(255));
                end
            endcase
            wait_idle();
            write_reg(REG_BYTES_PER_LINE, bpl);
            write_reg(REG_MIN_ADDRESS_BYTES, min_bytes);
            if (p == 3) begin
                write_reg(REG_SPARE_2, 8'($urandom_range(255)));
                write_reg(REG_SPARE_3, 8'($urandom_range(255)));
            end
            calm = (p == 2);
            if (bpl == 8'd255) begin
                // enough contiguous bytes to wrap the longest line
                send_run($urandom, 258);
                random_phase(20);
            end else begin
                random_phase(PHASE_ITEMS);
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
